### src/ssc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

   localparam int unsigned VALUE_W = 16;
   localparam int unsigned COUNT_W = 30;
   localparam int unsigned ADDR_W  = 10;
   localparam int unsigned MAX_SUM = 1023;

   localparam logic [COUNT_W-1:0] WAY_MOD = COUNT_W'(1000000007);
   localparam logic [ADDR_W-1:0]  TOP_ADDR = ADDR_W'(MAX_SUM);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_FETCH,
      ST_LOAD
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the incoming element and restart the sweep counter
      logic step;      // read the table at the sweep counter and step down
      logic fetch;     // read the table entry at the target sum
      logic load;      // move the fetched count into the result register
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last_addr;   // sweep counter stands at entry zero
      logic elem_last;   // the element being applied closes its set
      logic out_busy;    // result register holds a beat that is not taken this cycle
   } ctrl_status_type;

endpackage

`default_nettype wire

### src/ssc_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ssc_req_if;
   logic                               valid;
   logic                               ready;
   logic [ssc_pkg::VALUE_W-1:0]        element_value;
   logic                               last_element;

   modport source (output valid, output element_value, output last_element, input ready);
   modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

`default_nettype wire

### src/ssc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ssc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [ssc_pkg::COUNT_W-1:0]        way_count;

   modport source (output valid, output way_count, input ready);
   modport sink   (input valid, input way_count, output ready);
endinterface

`default_nettype wire

### src/ssc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ssc_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire ssc_pkg::ctrl_status_type status,
   output ssc_pkg::ctrl_cmd_type         cmd
);

   ssc_pkg::state_type state_ff;
   ssc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ssc_pkg::ST_SWEEP;
            end
         end
         ssc_pkg::ST_SWEEP: begin
            if (status.last_addr) begin
               state_in = ssc_pkg::ST_DRAIN;
            end
         end
         ssc_pkg::ST_DRAIN: begin
            state_in = status.elem_last ? ssc_pkg::ST_FETCH : ssc_pkg::ST_IDLE;
         end
         ssc_pkg::ST_FETCH: begin
            state_in = ssc_pkg::ST_LOAD;
         end
         ssc_pkg::ST_LOAD: begin
            if (!status.out_busy) begin
               state_in = ssc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ssc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         ssc_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ssc_pkg::ST_SWEEP: begin
            cmd.step = 1'b1;
         end
         ssc_pkg::ST_DRAIN: begin
         end
         ssc_pkg::ST_FETCH: begin
            cmd.fetch = 1'b1;
         end
         ssc_pkg::ST_LOAD: begin
            cmd.load = !status.out_busy;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

### src/ssc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ssc_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ssc_pkg::ctrl_cmd_type           cmd,
   output ssc_pkg::ctrl_status_type             status,
   input  wire logic [ssc_pkg::VALUE_W-1:0]     element_value,
   input  wire logic                            last_element,
   input  wire logic                            csr_wr_en,
   input  wire logic [ssc_pkg::ADDR_W-1:0]      csr_wr_data,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output logic [ssc_pkg::COUNT_W-1:0]          rsp_way_count
);

   logic [ssc_pkg::COUNT_W-1:0] count_mem [0:ssc_pkg::MAX_SUM];

   logic [ssc_pkg::ADDR_W-1:0]  target_sum_ff;
   logic                        new_set_pending_ff;
   logic [ssc_pkg::VALUE_W-1:0] elem_value_ff;
   logic                        elem_last_ff;
   logic                        fresh_ff;
   logic [ssc_pkg::ADDR_W-1:0]  cnt_ff;

   logic                        s1_valid_ff;
   logic [ssc_pkg::ADDR_W-1:0]  s1_addr_ff;
   logic                        s1_use_b_ff;
   logic [ssc_pkg::COUNT_W-1:0] rd_a_ff;
   logic [ssc_pkg::COUNT_W-1:0] rd_b_ff;

   logic                        rsp_valid_ff;
   logic [ssc_pkg::COUNT_W-1:0] way_count_ff;

   logic [ssc_pkg::ADDR_W-1:0]  rd_a_addr;
   logic [ssc_pkg::ADDR_W-1:0]  rd_b_addr;
   logic                        use_b;
   logic [ssc_pkg::COUNT_W:0]   sum_raw;
   logic [ssc_pkg::COUNT_W-1:0] sum_mod;
   logic [1:0]                  fresh_val;
   logic                        wr_en;
   logic [ssc_pkg::COUNT_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_sum_ff      <= '0;
         new_set_pending_ff <= 1'b1;
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            target_sum_ff <= csr_wr_data;
         end
         if (cmd.capture) begin
            new_set_pending_ff <= last_element;
         end
         s1_valid_ff <= cmd.step;
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Element registers and the sweep counter.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         elem_value_ff <= element_value;
         elem_last_ff  <= last_element;
         fresh_ff      <= new_set_pending_ff;
         cnt_ff        <= ssc_pkg::TOP_ADDR;
      end else if (cmd.step) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
      s1_addr_ff  <= cnt_ff;
      s1_use_b_ff <= use_b;
      if (cmd.load) begin
         way_count_ff <= rd_a_ff;
      end
   end

   assign use_b     = {{(ssc_pkg::VALUE_W-ssc_pkg::ADDR_W){1'b0}}, cnt_ff} >= elem_value_ff;
   assign rd_a_addr = cmd.fetch ? target_sum_ff : cnt_ff;
   assign rd_b_addr = cnt_ff - elem_value_ff[ssc_pkg::ADDR_W-1:0];

   // Table memory: two registered reads and one write per cycle. The sweep walks
   // downward, so reads never touch an entry whose write is still in flight.
   always_ff @(posedge clock) begin
      if (cmd.step || cmd.fetch) begin
         rd_a_ff <= count_mem[rd_a_addr];
      end
      if (cmd.step) begin
         rd_b_ff <= count_mem[rd_b_addr];
      end
      if (wr_en) begin
         count_mem[s1_addr_ff] <= wr_data;
      end
   end

   always_comb begin
      sum_raw = {1'b0, rd_a_ff} + {1'b0, rd_b_ff};
      if (sum_raw >= {1'b0, ssc_pkg::WAY_MOD}) begin
         sum_mod = ssc_pkg::COUNT_W'(sum_raw - {1'b0, ssc_pkg::WAY_MOD});
      end else begin
         sum_mod = sum_raw[ssc_pkg::COUNT_W-1:0];
      end
      // On the first element of a set the old table is the cleared one.
      fresh_val = {1'b0, (s1_addr_ff == '0)}
                + {1'b0, ({{(ssc_pkg::VALUE_W-ssc_pkg::ADDR_W){1'b0}}, s1_addr_ff}
                          == elem_value_ff)};
      wr_en   = s1_valid_ff && (fresh_ff || s1_use_b_ff);
      wr_data = fresh_ff ? {{(ssc_pkg::COUNT_W-2){1'b0}}, fresh_val} : sum_mod;
   end

   assign status.last_addr = (cnt_ff == '0);
   assign status.elem_last = elem_last_ff;
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_way_count = way_count_ff;

endmodule

`default_nettype wire

### src/subset_sum_count_mod.sv
`timescale 1ns / 1ps
`default_nettype none

// Subset-sum counter modulo 1000000007. Each request beat carries one element of a
// set; the beat marked last_element produces one response beat with the number of
// subsets of that set whose elements add up to the target sum, modulo 1000000007.
// The target comes from the csr port and is sampled when the last element finishes,
// so it may be written at any idle time within a set. Every element sweeps the whole
// 1024-entry count table, one entry per cycle through the single read-add-write path
// of the table memory. A request beat is therefore accepted only once the previous
// sweep has run out, the drain state has retired the last table write and the
// controller is back in idle; a last element also needs the fetch of the target entry
// and the load of the result register before that. The first element of each set
// rewrites every entry from the cleared table, so no clearing pass is needed after
// reset or between sets. A finished result sits in an output register and does not
// hold up the next element; only a second result can wait on it.

module subset_sum_count_mod (
   input  wire logic                        clock,
   input  wire logic                        reset,
   ssc_req_if.sink                          req_ch,
   ssc_rsp_if.source                        rsp_ch,
   input  wire logic                        csr_wr_en,
   input  wire logic [ssc_pkg::ADDR_W-1:0]  csr_wr_data
);

   ssc_pkg::ctrl_cmd_type    cmd;
   ssc_pkg::ctrl_status_type status;

   // Sequencer: one sweep per element, then the optional result fetch.
   ssc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Count table, modular adder and the result register.
   ssc_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .element_value (req_ch.element_value),
      .last_element  (req_ch.last_element),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_way_count (rsp_ch.way_count)
   );

   // An accepted beat starts a sweep, so the next cycle cannot accept another.
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request accepted while a sweep was starting");

   // A response beat appears only after the controller loaded it.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(cmd.load))
      else $error("response valid without a load");

   // Loading never overwrites a beat that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !status.out_busy)
      else $error("result register overwritten");

   // The table read port serves either the sweep or the result fetch.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.step && cmd.fetch))
      else $error("sweep and fetch collide on the read port");

endmodule

`default_nettype wire
